// ===== rtl/core/command_ack_tracker_macros.svh =====
// Assertion helpers used by the tracker controller.
`ifndef COMMAND_ACK_TRACKER_MACROS_SVH
`define COMMAND_ACK_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CAT_IMPLY(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tracker check failed");

// Next-cycle implication, checked outside reset.
`define CAT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tracker check failed");

`endif

// ===== rtl/core/cat_pkg.sv =====
package cat_pkg;

  localparam logic [1:0] CmdExpect  = 2'd0;
  localparam logic [1:0] CmdObserve = 2'd1;
  localparam logic [1:0] CmdTick    = 2'd2;
  localparam logic [1:0] CmdCancel  = 2'd3;

  localparam logic [3:0] KindRegistered = 4'd0;
  localparam logic [3:0] KindRefused    = 4'd1;
  localparam logic [3:0] KindFull       = 4'd2;
  localparam logic [3:0] KindMatched    = 4'd3;
  localparam logic [3:0] KindDuplicate  = 4'd4;
  localparam logic [3:0] KindUnexpected = 4'd5;
  localparam logic [3:0] KindStale      = 4'd6;
  localparam logic [3:0] KindRejected   = 4'd7;
  localparam logic [3:0] KindTimedOut   = 4'd8;
  localparam logic [3:0] KindCancelled  = 4'd9;
  localparam logic [3:0] KindCancelRef  = 4'd10;

  localparam logic [1:0] PhWait = 2'd0;
  localparam logic [1:0] PhSat  = 2'd1;
  localparam logic [1:0] PhTout = 2'd2;
  localparam logic [1:0] PhCanc = 2'd3;

  localparam logic [2:0] AckAccepted = 3'd0;
  localparam logic [2:0] AckRejected = 3'd1;
  localparam logic [2:0] AckUnknown  = 3'd3;

  // Timeouts reported by one sweep at most.
  localparam logic [4:0] MaxOut = 5'd16;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic exec;
    logic tick_read;
    logic tick_load;
    logic tick_next;
    logic flush_done;
  } cat_ctrl_t;

  typedef struct packed {
    logic is_tick;
    logic tmo;
    logic pending;
    logic capped;
    logic idx_end;
  } cat_stat_t;

  typedef struct packed {
    logic [15:0] device;
    logic [63:0] deadline;
    logic [7:0]  required;
    logic [7:0]  accepts;
    logic        rejects;
    logic [63:0] latest;
  } cat_word_t;

endpackage

// ===== rtl/core/cat_ctrl.sv =====
`include "command_ack_tracker_macros.svh"

module cat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              last,
  output cat_pkg::cat_ctrl_t ctrl,
  input  cat_pkg::cat_stat_t stat
);
  import cat_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOOK   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_OUT    = 8'b0000_1000,
    S_TRD    = 8'b0001_0000,
    S_TCHK   = 8'b0010_0000,
    S_TFLUSH = 8'b0100_0000,
    S_TLAST  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT) || (state == S_TFLUSH) || (state == S_TLAST);
  assign last      = (state == S_OUT) || (state == S_TLAST);

  always_comb begin
    state_next = state;
    ctrl = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.is_tick) begin
          state_next = S_TRD;
        end else begin
          ctrl.lookup = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      S_TRD: begin
        ctrl.tick_read = 1'b1;
        state_next = S_TCHK;
      end
      S_TCHK: begin
        if (stat.capped) begin
          state_next = S_TLAST;
        end else if (stat.tmo && stat.pending) begin
          state_next = S_TFLUSH;
        end else begin
          ctrl.tick_load = stat.tmo;
          if (stat.idx_end) begin
            state_next = (stat.tmo || stat.pending) ? S_TLAST : S_IDLE;
          end else begin
            ctrl.tick_next = 1'b1;
            state_next = S_TRD;
          end
        end
      end
      S_TFLUSH: begin
        if (out_ready) begin
          ctrl.flush_done = 1'b1;
          state_next = S_TCHK;
        end
      end
      S_TLAST: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `CAT_IMPLY(a_no_overlap, clk, rst, in_ready, !out_valid)
  `CAT_IMPLY(a_load_clean, clk, rst, ctrl.tick_load, stat.tmo && !stat.pending)
  `CAT_NEXT(a_capture_go, clk, rst, in_valid && in_ready, state == S_LOOK)
  `CAT_IMPLY(a_tlast_pending, clk, rst, state == S_TLAST, stat.pending)

endmodule

// ===== rtl/core/cat_dp.sv =====
module cat_dp #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cat_pkg::cat_ctrl_t ctrl,
  output cat_pkg::cat_stat_t stat,
  input  logic [1:0]         command,
  input  logic [31:0]        cmd_id,
  input  logic [15:0]        device,
  input  logic [63:0]        time_ns,
  input  logic [63:0]        due_ns,
  input  logic [7:0]         accepts_needed,
  input  logic [2:0]         ack_status,
  output logic [3:0]         kind,
  output logic [31:0]        result_id,
  output logic [15:0]        result_device,
  output logic [63:0]        result_time_ns,
  output logic [1:0]         entry_state,
  output logic [7:0]         accepts_count,
  output logic               rejects_count,
  output logic [63:0]        latest_time_ns
);
  import cat_pkg::*;

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // captured word
  logic [1:0]  cmd_q;
  logic [31:0] id_q;
  logic [15:0] dev_q;
  logic [63:0] t_q;
  logic [63:0] dl_q;
  logic [7:0]  req_q;
  logic [2:0]  st_q;

  logic              valid [ENTRIES];
  logic [31:0]       ids   [ENTRIES];
  logic [1:0]        phase [ENTRIES];
  cat_word_t         mem   [ENTRIES];
  cat_word_t         rd_data;

  logic              hit_c, free_c, term_c;
  logic [IdxW-1:0]   hit_idx_c, free_idx_c, term_idx_c;
  logic              hit_q, slot_ok_q;
  logic [IdxW-1:0]   hit_idx_q, slot_idx_q;

  logic [IdxW-1:0]   tick_idx;
  logic [4:0]        n_out;
  logic              pending;

  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;
  cat_word_t         wr_word;
  logic              tbl_wr;
  logic              tbl_new;
  logic [1:0]        ph_new;

  logic [3:0]  kind_n;
  logic [15:0] dev_n;
  logic [63:0] time_n;
  logic [1:0]  es_n;
  logic [7:0]  acc_n;
  logic        rej_n;
  logic [63:0] lat_n;
  logic [31:0] rid_n;

  logic [1:0]  hp;
  logic [63:0] mx_t;
  logic [7:0]  inc_acc;

  // Parallel id compare and slot search; lowest index wins.
  always_comb begin
    hit_c = 1'b0; free_c = 1'b0; term_c = 1'b0;
    hit_idx_c = '0; free_idx_c = '0; term_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && ids[i] == id_q) begin
        hit_c = 1'b1; hit_idx_c = IdxW'(i);
      end
      if (!valid[i]) begin
        free_c = 1'b1; free_idx_c = IdxW'(i);
      end
      if (valid[i] && phase[i] != PhWait) begin
        term_c = 1'b1; term_idx_c = IdxW'(i);
      end
    end
  end

  assign rd_en   = ctrl.lookup || ctrl.tick_read;
  assign rd_addr = ctrl.lookup ? hit_idx_c : tick_idx;

  assign hp      = phase[hit_idx_q];
  assign mx_t    = (t_q > rd_data.latest) ? t_q : rd_data.latest;
  assign inc_acc = (rd_data.accepts == 8'hFF) ? rd_data.accepts : rd_data.accepts + 8'd1;

  assign stat.is_tick = (cmd_q == CmdTick);
  assign stat.tmo     = valid[tick_idx] && phase[tick_idx] == PhWait &&
                        rd_data.deadline != 64'd0 && t_q >= rd_data.deadline;
  assign stat.pending = pending;
  assign stat.capped  = (n_out == MaxOut);
  assign stat.idx_end = (tick_idx == IdxW'(ENTRIES - 1));

  // Result and table update for one non-sweep word, or for one timeout.
  always_comb begin
    kind_n = KindRefused; rid_n = id_q; dev_n = dev_q; time_n = '0;
    es_n = PhWait; acc_n = '0; rej_n = 1'b0; lat_n = '0;
    wr_en = 1'b0; wr_idx = hit_idx_q; wr_word = rd_data;
    tbl_wr = 1'b0; tbl_new = 1'b0; ph_new = hp;
    if (ctrl.tick_load) begin
      kind_n = KindTimedOut; rid_n = ids[tick_idx]; dev_n = rd_data.device;
      time_n = t_q; es_n = PhTout; acc_n = rd_data.accepts;
      rej_n = rd_data.rejects; lat_n = mx_t;
      wr_en = 1'b1; wr_idx = tick_idx; wr_word.latest = mx_t;
      tbl_wr = 1'b1; ph_new = PhTout;
    end else begin
      case (cmd_q)
        CmdExpect: begin
          if (id_q == 32'd0) begin
            kind_n = KindRefused;
          end else if (hit_q && hp == PhWait) begin
            kind_n = KindRefused; es_n = hp; acc_n = rd_data.accepts;
            rej_n = rd_data.rejects; lat_n = rd_data.latest;
          end else if (!hit_q && !slot_ok_q) begin
            kind_n = KindFull;
          end else begin
            kind_n = KindRegistered;
            wr_en = 1'b1; wr_idx = hit_q ? hit_idx_q : slot_idx_q;
            wr_word.device = dev_q; wr_word.deadline = dl_q;
            wr_word.required = (req_q == 8'd0) ? 8'd1 : req_q;
            wr_word.accepts = '0; wr_word.rejects = 1'b0; wr_word.latest = '0;
            tbl_wr = 1'b1; tbl_new = 1'b1; ph_new = PhWait;
          end
        end
        CmdObserve: begin
          time_n = t_q;
          if (!hit_q) begin
            kind_n = KindUnexpected;
          end else begin
            if (hp != PhWait) kind_n = KindDuplicate;
            else if (dev_q != rd_data.device) kind_n = KindUnexpected;
            else if (rd_data.deadline != 64'd0 && t_q > rd_data.deadline) kind_n = KindStale;
            else if (st_q == AckAccepted)
              kind_n = (rd_data.accepts >= rd_data.required) ? KindDuplicate : KindMatched;
            else if (st_q >= AckRejected && st_q <= AckUnknown) kind_n = KindRejected;
            else kind_n = KindMatched;
            acc_n = rd_data.accepts; rej_n = rd_data.rejects; ph_new = hp;
            if (kind_n == KindMatched) begin
              acc_n = inc_acc;
              if (inc_acc >= rd_data.required) ph_new = PhSat;
            end else if (kind_n == KindRejected) begin
              rej_n = 1'b1; ph_new = PhSat;
            end
            es_n = ph_new; lat_n = mx_t;
            wr_en = 1'b1; wr_word.accepts = acc_n; wr_word.rejects = rej_n;
            wr_word.latest = mx_t; tbl_wr = 1'b1;
          end
        end
        CmdCancel: begin
          dev_n = '0;
          if (!hit_q) begin
            kind_n = KindCancelRef;
          end else begin
            kind_n = (hp == PhWait) ? KindCancelled : KindCancelRef;
            dev_n = rd_data.device; time_n = rd_data.latest;
            ph_new = (hp == PhWait) ? PhCanc : hp;
            es_n = ph_new; acc_n = rd_data.accepts; rej_n = rd_data.rejects;
            lat_n = rd_data.latest; tbl_wr = 1'b1;
          end
        end
        default: kind_n = KindRefused;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q <= command; id_q <= cmd_id; dev_q <= device; t_q <= time_ns;
      dl_q <= due_ns; req_q <= accepts_needed; st_q <= ack_status;
    end
    if (ctrl.lookup) begin
      hit_q <= hit_c; hit_idx_q <= hit_idx_c;
      slot_ok_q <= free_c || term_c;
      slot_idx_q <= free_c ? free_idx_c : term_idx_c;
    end
    if (rd_en) rd_data <= mem[rd_addr];
    if (wr_en && (ctrl.exec || ctrl.tick_load)) mem[wr_idx] <= wr_word;
    if (tbl_wr && (ctrl.exec || ctrl.tick_load)) begin
      phase[wr_idx] <= ph_new;
      if (tbl_new) ids[wr_idx] <= id_q;
    end
    if (ctrl.exec || ctrl.tick_load) begin
      kind <= kind_n; result_id <= rid_n; result_device <= dev_n;
      result_time_ns <= time_n; entry_state <= es_n; accepts_count <= acc_n;
      rejects_count <= rej_n; latest_time_ns <= lat_n;
    end
  end

  // Cancel keeps its slot index in hit_idx_q, so wr_idx is right there too.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) valid[i] <= 1'b0;
      pending <= 1'b0; n_out <= '0; tick_idx <= '0;
    end else begin
      if (ctrl.exec && tbl_new) valid[wr_idx] <= 1'b1;
      if (ctrl.capture) begin
        pending <= 1'b0; n_out <= '0; tick_idx <= '0;
      end else begin
        if (ctrl.tick_load) begin
          pending <= 1'b1; n_out <= n_out + 5'd1;
        end else if (ctrl.flush_done) begin
          pending <= 1'b0;
        end
        if (ctrl.tick_next) tick_idx <= tick_idx + IdxW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/command_ack_tracker.sv =====
// Command acknowledgement tracker: id-matched table of outstanding commands.
// Expect, observe and cancel: after the accepting edge, a lookup with table read,
// then the update into the result register; one word in flight.
// Tick: sweeps the table slot by slot and may stall on the output; timeouts are
// held one behind for last.
// Reset (rst, synchronous, active high) clears slot valid bits and control.
module command_ack_tracker #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] cmd_id,
  input  logic [15:0] device,
  input  logic [63:0] time_ns,
  input  logic [63:0] due_ns,
  input  logic [7:0]  accepts_needed,
  input  logic [2:0]  ack_status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [31:0] result_id,
  output logic [15:0] result_device,
  output logic [63:0] result_time_ns,
  output logic [1:0]  entry_state,
  output logic [7:0]  accepts_count,
  output logic        rejects_count,
  output logic [63:0] latest_time_ns,
  output logic        last
);
  import cat_pkg::*;

  // Command and status between the sequencer and the table datapath.
  cat_ctrl_t ctrl;
  cat_stat_t stat;

  // Sequence each word: capture, lookup, update, then hold the result; a tick sweeps the table instead.
  cat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .last      (last),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  // Hold the slot table, the slot memory and the result register.
  cat_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .command        (command),
    .cmd_id         (cmd_id),
    .device         (device),
    .time_ns        (time_ns),
    .due_ns         (due_ns),
    .accepts_needed (accepts_needed),
    .ack_status     (ack_status),
    .kind           (kind),
    .result_id      (result_id),
    .result_device  (result_device),
    .result_time_ns (result_time_ns),
    .entry_state    (entry_state),
    .accepts_count  (accepts_count),
    .rejects_count  (rejects_count),
    .latest_time_ns (latest_time_ns)
  );

endmodule

// ===== verif/tb_command_ack_tracker.sv =====
module tb_command_ack_tracker;
  import cat_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [3:0] NoKind = 4'hF;  // row carries no typed-in kind
  localparam logic [63:0] TMAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // One input word as driven on the input channel, plus an optional typed kind.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] id;
    logic [15:0] dev;
    logic [63:0] stamp;
    logic [63:0] dline;
    logic [7:0]  req;
    logic [2:0]  status;
    logic [3:0]  want_kind;
  } ack_word_t;

  // One result word as seen on the output channel.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] id;
    logic [15:0] dev;
    logic [63:0] stamp;
    logic [1:0]  phase;
    logic [7:0]  accepts;
    logic        rejects;
    logic [63:0] latest;
    logic        last;
  } ack_res_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [31:0] cmd_id;
  logic [15:0] device;
  logic [63:0] time_ns;
  logic [63:0] due_ns;
  logic [7:0]  accepts_needed;
  logic [2:0]  ack_status;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  kind;
  logic [31:0] result_id;
  logic [15:0] result_device;
  logic [63:0] result_time_ns;
  logic [1:0]  entry_state;
  logic [7:0]  accepts_count;
  logic        rejects_count;
  logic [63:0] latest_time_ns;
  logic        last;

  command_ack_tracker dut (.*);

  // Shadow copy of the slot table, used to work out each expected result.
  logic        tab_valid [SLOTS];
  logic [31:0] tab_id    [SLOTS];
  logic [15:0] tab_dev   [SLOTS];
  logic [63:0] tab_dline [SLOTS];
  logic [7:0]  tab_req   [SLOTS];
  logic [7:0]  tab_acc   [SLOTS];
  logic        tab_rej   [SLOTS];
  logic [1:0]  tab_phase [SLOTS];
  logic [63:0] tab_latest[SLOTS];

  ack_res_t due_results[$];
  int       fail_count;
  bit       tx_idle;      // sender may insert gaps
  bit       rx_idle;      // receiver may stall at random
  bit       hold_req;     // ask the receiver for one long hold-off
  logic [63:0] now_ns;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 1500000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int find_id(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (tab_valid[i] && tab_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Build a result word; entry fields come from slot s, or are zero for s < 0.
  function automatic ack_res_t make_res(logic [3:0] k, logic [31:0] id, logic [15:0] dev,
                                        logic [63:0] stamp, int s, logic lst);
    ack_res_t r;
    r = '0;
    r.kind = k;
    r.id = id;
    r.dev = dev;
    r.stamp = stamp;
    r.last = lst;
    if (s >= 0) begin
      r.phase = tab_phase[s];
      r.accepts = tab_acc[s];
      r.rejects = tab_rej[s];
      r.latest = tab_latest[s];
    end
    return r;
  endfunction

  // Apply one accepted word to the shadow table and queue its results.
  task automatic track_word(ack_word_t w);
    int s;
    int n;
    logic [3:0] k;
    ack_res_t r;
    ack_res_t outs[$];
    s = find_id(w.id);
    case (w.cmd)
      CmdExpect: begin
        if (w.id == 0) begin
          outs = {outs, make_res(KindRefused, w.id, w.dev, 64'd0, -1, 1'b1)};
        end else if (s >= 0 && tab_phase[s] == PhWait) begin
          outs = {outs, make_res(KindRefused, w.id, w.dev, 64'd0, s, 1'b1)};
        end else begin
          // Reuse a terminal entry of the same id, else free slot, else terminal slot.
          for (int i = 0; s < 0 && i < SLOTS; i++) if (!tab_valid[i]) s = i;
          for (int i = 0; s < 0 && i < SLOTS; i++) if (tab_phase[i] != PhWait) s = i;
          if (s < 0) begin
            outs = {outs, make_res(KindFull, w.id, w.dev, 64'd0, -1, 1'b1)};
          end else begin
            tab_valid[s] = 1'b1;
            tab_id[s] = w.id;
            tab_dev[s] = w.dev;
            tab_dline[s] = w.dline;
            tab_req[s] = (w.req == 8'd0) ? 8'd1 : w.req;
            tab_acc[s] = 8'd0;
            tab_rej[s] = 1'b0;
            tab_phase[s] = PhWait;
            tab_latest[s] = 64'd0;
            outs = {outs, make_res(KindRegistered, w.id, w.dev, 64'd0, s, 1'b1)};
          end
        end
      end
      CmdObserve: begin
        if (s < 0) begin
          outs = {outs, make_res(KindUnexpected, w.id, w.dev, w.stamp, -1, 1'b1)};
        end else begin
          if (tab_phase[s] != PhWait) k = KindDuplicate;
          else if (w.dev != tab_dev[s]) k = KindUnexpected;
          else if (tab_dline[s] != 0 && w.stamp > tab_dline[s]) k = KindStale;
          else if (w.status == AckAccepted)
            k = (tab_acc[s] >= tab_req[s]) ? KindDuplicate : KindMatched;
          else if (w.status >= AckRejected && w.status <= AckUnknown) k = KindRejected;
          else k = KindMatched;  // other status codes count as an accept
          if (w.stamp > tab_latest[s]) tab_latest[s] = w.stamp;
          if (k == KindMatched) begin
            if (tab_acc[s] != 8'hFF) tab_acc[s]++;
            if (tab_acc[s] >= tab_req[s]) tab_phase[s] = PhSat;
          end else if (k == KindRejected) begin
            tab_rej[s] = 1'b1;
            tab_phase[s] = PhSat;
          end
          outs = {outs, make_res(k, w.id, w.dev, w.stamp, s, 1'b1)};
        end
      end
      CmdTick: begin
        n = 0;
        for (int i = 0; i < SLOTS && n < MaxOut; i++) begin
          if (tab_valid[i] && tab_phase[i] == PhWait && tab_dline[i] != 0 &&
              w.stamp >= tab_dline[i]) begin
            tab_phase[i] = PhTout;
            if (w.stamp > tab_latest[i]) tab_latest[i] = w.stamp;
            outs = {outs, make_res(KindTimedOut, tab_id[i], tab_dev[i], w.stamp, i,
                                   1'b0)};
            n++;
          end
        end
        if (n > 0) outs[n-1].last = 1'b1;
      end
      default: begin
        if (s < 0) begin
          outs = {outs, make_res(KindCancelRef, w.id, 16'd0, 64'd0, -1, 1'b1)};
        end else if (tab_phase[s] != PhWait) begin
          outs = {outs, make_res(KindCancelRef, w.id, tab_dev[s], tab_latest[s], s,
                                 1'b1)};
        end else begin
          tab_phase[s] = PhCanc;
          outs = {outs, make_res(KindCancelled, w.id, tab_dev[s], tab_latest[s], s,
                                 1'b1)};
        end
      end
    endcase
    // A typed-in kind in the directed table overrides the computed one.
    if (w.want_kind != NoKind && outs.size() > 0) outs[0].kind = w.want_kind;
    foreach (outs[i]) begin
      r = outs[i];
      due_results = {due_results, r};
    end
  endtask

  task automatic cmp_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, e, a);
      fail_count++;
    end
  endtask

  // Drive one word; hold valid and payload until accepted.
  task automatic send_word(ack_word_t w);
    while (tx_idle && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= w.cmd;
    cmd_id <= w.id;
    device <= w.dev;
    time_ns <= w.stamp;
    due_ns <= w.dline;
    accepts_needed <= w.req;
    ack_status <= w.status;
    do @(posedge clk); while (!in_ready);
    track_word(w);
  endtask

  // Random word: small id and device pools so most words hit table entries.
  function automatic ack_word_t pick_word();
    ack_word_t w;
    int s;
    int p;
    w = '0;
    w.want_kind = NoKind;
    p = $urandom_range(99);
    w.cmd = (p < 32) ? CmdExpect : (p < 70) ? CmdObserve : (p < 82) ? CmdTick : CmdCancel;
    p = $urandom_range(99);
    w.id = (p < 4) ? 32'd0 : (p < 9) ? $urandom : 32'($urandom_range(24, 1));
    w.dev = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    s = find_id(w.id);
    if (w.cmd == CmdObserve && s >= 0 && $urandom_range(9) < 8) w.dev = tab_dev[s];
    w.stamp = ($urandom_range(29) == 0) ? {$urandom, $urandom} : now_ns;
    p = $urandom_range(9);
    w.dline = (p < 3) ? 64'd0 : (p < 9) ? now_ns + $urandom_range(400, 20)
                                        : {$urandom, $urandom};
    w.req = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    w.status = ($urandom_range(1) == 0) ? AckAccepted : 3'($urandom_range(7));
    return w;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      now_ns = now_ns + $urandom_range(40);
      send_word(pick_word());
    end
  endtask

  // Pause the sender until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Receiver: check accepted words, stall at random or on a hold-off request.
  initial begin
    ack_res_t e;
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t mismatch: unexpected word, expected none actual kind %0h",
                   $realtime, kind);
          fail_count++;
        end else begin
          e = due_results.pop_front();
          cmp_field("kind", e.kind, kind);
          cmp_field("result_id", e.id, result_id);
          cmp_field("result_device", e.dev, result_device);
          cmp_field("result_time_ns", e.stamp, result_time_ns);
          cmp_field("entry_state", e.phase, entry_state);
          cmp_field("accepts_count", e.accepts, accepts_count);
          cmp_field("rejects_count", e.rejects, rejects_count);
          cmp_field("latest_time_ns", e.latest, latest_time_ns);
          cmp_field("last", e.last, last);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(rx_idle && $urandom_range(99) < 26);
      end
    end
  end

  // Directed words: kinds typed in where they follow at a glance.
  ack_word_t plan [23] = '{
    '{CmdExpect,  32'd0,         16'h0001, 64'd0,   64'd0,   8'd1,   AckAccepted, KindRefused},
    '{CmdExpect,  32'hFFFF_FFFF, 16'hFFFF, 64'd0,   64'd100, 8'd0,   AckAccepted, KindRegistered},
    '{CmdExpect,  32'hFFFF_FFFF, 16'hFFFF, 64'd0,   64'd0,   8'd1,   AckAccepted, KindRefused},
    '{CmdObserve, 32'd5,         16'h0001, 64'd10,  64'd0,   8'd0,   AckAccepted, KindUnexpected},
    '{CmdObserve, 32'hFFFF_FFFF, 16'h0001, 64'd10,  64'd0,   8'd0,   AckAccepted, KindUnexpected},
    '{CmdObserve, 32'hFFFF_FFFF, 16'hFFFF, 64'd200, 64'd0,   8'd0,   AckAccepted, KindStale},
    '{CmdTick,    32'd0,         16'h0000, 64'd50,  64'd0,   8'd0,   AckAccepted, NoKind},
    '{CmdTick,    32'd0,         16'h0000, 64'd100, 64'd0,   8'd0,   AckAccepted, KindTimedOut},
    '{CmdObserve, 32'hFFFF_FFFF, 16'hFFFF, 64'd90,  64'd0,   8'd0,   AckAccepted, KindDuplicate},
    '{CmdCancel,  32'hFFFF_FFFF, 16'h0000, 64'd0,   64'd0,   8'd0,   AckAccepted, KindCancelRef},
    '{CmdCancel,  32'd7,         16'h0000, 64'd0,   64'd0,   8'd0,   AckAccepted, KindCancelRef},
    '{CmdExpect,  32'd2,         16'h0003, 64'd0,   64'd0,   8'd2,   AckAccepted, KindRegistered},
    '{CmdObserve, 32'd2,         16'h0003, 64'd5,   64'd0,   8'd0,   AckAccepted, KindMatched},
    '{CmdObserve, 32'd2,         16'h0003, 64'd4,   64'd0,   8'd0,   3'd4,        KindMatched},
    '{CmdObserve, 32'd2,         16'h0003, 64'd6,   64'd0,   8'd0,   AckAccepted, KindDuplicate},
    '{CmdExpect,  32'd2,         16'h0000, 64'd0,   64'd0,   8'hFF,  AckAccepted, KindRegistered},
    '{CmdObserve, 32'd2,         16'h0000, 64'd7,   64'd0,   8'd0,   AckRejected, KindRejected},
    '{CmdExpect,  32'd3,         16'h0008, 64'd0,   TMAX,    8'hFF,  AckAccepted, KindRegistered},
    '{CmdObserve, 32'd3,         16'h0008, TMAX,    64'd0,   8'd0,   AckAccepted, KindMatched},
    '{CmdObserve, 32'd3,         16'h0008, 64'd1,   64'd0,   8'd0,   3'd7,        KindMatched},
    '{CmdCancel,  32'd3,         16'h0000, 64'd0,   64'd0,   8'd0,   AckAccepted, KindCancelled},
    '{CmdTick,    32'd0,         16'h0000, TMAX,    64'd0,   8'd0,   AckAccepted, NoKind},
    '{CmdObserve, 32'd2,         16'h0000, 64'd9,   64'd0,   8'd0,   3'd2,        KindDuplicate}
  };

  initial begin
    ack_word_t w;
    fail_count = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    now_ns = 64'd1000;
    for (int i = 0; i < SLOTS; i++) tab_valid[i] = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CmdExpect;
    cmd_id = '0;
    device = '0;
    time_ns = '0;
    due_ns = '0;
    accepts_needed = '0;
    ack_status = AckAccepted;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_word(plan[i]);
    drain();

    // Fill every slot with a deadline, then sweep them all out in one tick.
    for (int i = 0; i < SLOTS; i++) begin
      w = pick_word();
      w.cmd = CmdExpect;
      w.id = 32'd100 + i;
      w.dline = now_ns + 10;
      send_word(w);
    end
    w.id = 32'd200;
    send_word(w);  // table full
    w.cmd = CmdTick;
    w.stamp = now_ns + 10;
    send_word(w);
    drain();

    send_random(130);

    // Long receiver hold-off while the sender keeps offering words.
    hold_req = 1'b1;
    send_random(40);
    drain();

    // A stretch with no idling on either side.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_random(100);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_random(100);

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== command_ack_tracker.f =====
+incdir+rtl/core
rtl/core/cat_pkg.sv
rtl/core/cat_ctrl.sv
rtl/core/cat_dp.sv
rtl/core/command_ack_tracker.sv
verif/tb_command_ack_tracker.sv
